// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the subdivision block; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/core/sts_pkg.sv
// Types and constants of the sphere triangle subdivision block.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

    localparam int COORD_W   = 18;
    localparam int FIELD_MAX = 131071;
    localparam int FIELD_NEG = 131072;
    localparam int TDATA_W   = 168;
    localparam int PAD_W     = TDATA_W - 9 * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [2:0] vec_t;

    typedef struct packed {
        vec_t v2;
        vec_t v1;
        vec_t v0;
    } tri_t;

    typedef enum logic [1:0] {
        CHILD_V0  = 2'd0,
        CHILD_V1  = 2'd1,
        CHILD_MID = 2'd2,
        CHILD_V2  = 2'd3
    } child_t;

endpackage
`default_nettype wire

// File: rtl/core/sts_mid.sv
// Pipelined edge midpoint normalizer: sum, length, long division, square root.
`timescale 1ns / 1ps
`default_nettype none
module sts_mid #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         en,
    input  sts_pkg::vec_t pa,
    input  sts_pkg::vec_t pb,
    output sts_pkg::vec_t r
);
    import sts_pkg::*;

    localparam int MW = COORD_W + 1;
    localparam int PW = 2 * MW;
    localparam int DW = PW + 2;
    localparam int QW = 2 * FRAC_BITS + 3;
    localparam int SW = FRAC_BITS + 2;
    localparam int EW = (SW > COORD_W) ? SW : COORD_W;

    logic signed [MW-1:0] sum_c [3];
    logic [MW-1:0]        m1_reg [3];
    logic [2:0]           sg1_reg;
    logic [PW-1:0]        sq2_reg [3];
    logic [2:0]           sg2_reg;
    logic [PW-1:0]        sq3_reg [3];
    logic [DW-1:0]        len3_reg;
    logic [2:0]           sg3_reg;

    logic [DW-1:0] drem_reg [QW][3];
    logic [QW-1:0] dquo_reg [QW][3];
    logic [DW-1:0] dlen_reg [QW];
    logic [2:0]    dsg_reg  [QW];

    logic [2*SW-1:0] sx_reg   [SW][3];
    logic [SW+1:0]   srem_reg [SW][3];
    logic [SW-1:0]   sroot_reg[SW][3];
    logic            sz_reg   [SW];
    logic [2:0]      ssg_reg  [SW];

    vec_t r_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_c[i] = MW'(pa[i]) + MW'(pb[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i]  <= sum_c[i][MW-1] ? MW'(-sum_c[i]) : MW'(sum_c[i]);
                sg1_reg[i] <= sum_c[i][MW-1];
                sq2_reg[i] <= PW'(m1_reg[i]) * PW'(m1_reg[i]);
                sq3_reg[i] <= sq2_reg[i];
            end
            sg2_reg  <= sg1_reg;
            sg3_reg  <= sg2_reg;
            len3_reg <= DW'(sq2_reg[0]) + DW'(sq2_reg[1]) + DW'(sq2_reg[2]);
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        logic [DW-1:0] lin;
        logic [2:0]    sgin;
        if (s == 0)
        begin : g_first
            assign lin  = len3_reg;
            assign sgin = sg3_reg;
        end
        else
        begin : g_next
            assign lin  = dlen_reg[s-1];
            assign sgin = dsg_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dlen_reg[s] <= lin;
                dsg_reg[s]  <= sgin;
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [DW-1:0] rin;
            logic          bin;
            logic [QW-1:0] qin;
            logic [DW:0]   t;
            logic          ge;
            if (s == 0)
            begin : g_first
                assign rin = DW'(sq3_reg[i] >> 1);
                assign bin = sq3_reg[i][0];
                assign qin = '0;
            end
            else
            begin : g_next
                assign rin = drem_reg[s-1][i];
                assign bin = 1'b0;
                assign qin = dquo_reg[s-1][i];
            end
            assign t  = {rin, bin};
            assign ge = (t >= {1'b0, lin});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[s][i] <= ge ? DW'(t - {1'b0, lin}) : DW'(t);
                    dquo_reg[s][i] <= {qin[QW-2:0], ge};
                end
            end
        end
    end

    for (genvar s = 0; s < SW; s++)
    begin : g_sqrt
        logic       zin;
        logic [2:0] sgin;
        if (s == 0)
        begin : g_first
            assign zin  = (dlen_reg[QW-1] == '0);
            assign sgin = dsg_reg[QW-1];
        end
        else
        begin : g_next
            assign zin  = sz_reg[s-1];
            assign sgin = ssg_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sz_reg[s]  <= zin;
                ssg_reg[s] <= sgin;
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [2*SW-1:0] xin;
            logic [SW+1:0]   rin;
            logic [SW-1:0]   oin;
            logic [SW+3:0]   t;
            logic [SW+3:0]   trial;
            logic            ge;
            if (s == 0)
            begin : g_first
                assign xin = (2*SW)'(dquo_reg[QW-1][i]);
                assign rin = '0;
                assign oin = '0;
            end
            else
            begin : g_next
                assign xin = sx_reg[s-1][i];
                assign rin = srem_reg[s-1][i];
                assign oin = sroot_reg[s-1][i];
            end
            assign t     = {rin, xin[2*SW-1 -: 2]};
            assign trial = (SW+4)'({oin, 2'b01});
            assign ge    = (t >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sx_reg[s][i]    <= {xin[2*SW-3:0], 2'b00};
                    srem_reg[s][i]  <= ge ? (SW+2)'(t - trial) : (SW+2)'(t);
                    sroot_reg[s][i] <= {oin[SW-2:0], ge};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [SW:0]   nsum;
        logic [EW-1:0] nx;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nsum = (SW+1)'(sroot_reg[SW-1][i]) + (SW+1)'(1);
                nx   = EW'(nsum[SW:1]);
                if (sz_reg[SW-1])
                begin
                    r_reg[i] <= '0;
                end
                else if (ssg_reg[SW-1][i])
                begin
                    r_reg[i] <= (nx > EW'(FIELD_NEG)) ? coord_t'(-FIELD_NEG)
                              : coord_t'(COORD_W'(0) - nx[COORD_W-1:0]);
                end
                else
                begin
                    r_reg[i] <= (nx > EW'(FIELD_MAX)) ? coord_t'(FIELD_MAX)
                              : coord_t'(nx[COORD_W-1:0]);
                end
            end
        end
    end

    assign r = r_reg;

endmodule
`default_nettype wire

// File: rtl/core/sphere_triangle_subdivide_top.sv
// The output channel sends four children per triangle, each held until accepted.
// The pipeline takes a new triangle every cycle while the output holder has room.
// Reset: rst_n asynchronous, active low; clears pipeline valid bits and the
// output holder's busy flag and child index.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sphere_triangle_subdivide_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero pad
    input  logic [sts_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z, zero pad
    output logic [sts_pkg::TDATA_W-1:0]   m_axis_tdata,
    // child_index
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import sts_pkg::*;

    localparam int L = 3 * FRAC_BITS + 9;

    tri_t   in_tri;
    vec_t   mid_a;
    vec_t   mid_b;
    vec_t   mid_c;
    logic   en;
    logic   load;

    logic [L-1:0] vld_reg;
    tri_t         line_reg [L];

    tri_t   hv_reg;
    vec_t   ha_reg;
    vec_t   hb_reg;
    vec_t   hc_reg;
    child_t cnt_reg;
    logic   busy_reg;

    vec_t   p0;
    vec_t   p1;
    vec_t   p2;

    assign in_tri = tri_t'(s_axis_tdata[9*COORD_W-1:0]);

    sts_mid #(.FRAC_BITS(FRAC_BITS)) u_mid_a (
        .clk (clk),
        .en  (en),
        .pa  (in_tri.v0),
        .pb  (in_tri.v2),
        .r   (mid_a)
    );

    sts_mid #(.FRAC_BITS(FRAC_BITS)) u_mid_b (
        .clk (clk),
        .en  (en),
        .pa  (in_tri.v0),
        .pb  (in_tri.v1),
        .r   (mid_b)
    );

    sts_mid #(.FRAC_BITS(FRAC_BITS)) u_mid_c (
        .clk (clk),
        .en  (en),
        .pa  (in_tri.v1),
        .pb  (in_tri.v2),
        .r   (mid_c)
    );

    assign load = vld_reg[L-1] &&
                  (!busy_reg || (m_axis_tready && cnt_reg == CHILD_V2));
    assign en   = !vld_reg[L-1] || load;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= in_tri;
            for (int k = 1; k < L; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= CHILD_V0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CHILD_V0;
        end
        else if (busy_reg && m_axis_tready)
        begin
            if (cnt_reg == CHILD_V2)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= child_t'(cnt_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hv_reg <= line_reg[L-1];
            ha_reg <= mid_a;
            hb_reg <= mid_b;
            hc_reg <= mid_c;
        end
    end

    always_comb
    begin
        unique case (cnt_reg)
            CHILD_V0:
            begin
                p0 = hv_reg.v0;
                p1 = hb_reg;
                p2 = ha_reg;
            end
            CHILD_V1:
            begin
                p0 = hb_reg;
                p1 = hv_reg.v1;
                p2 = hc_reg;
            end
            CHILD_MID:
            begin
                p0 = ha_reg;
                p1 = hb_reg;
                p2 = hc_reg;
            end
            default:
            begin
                p0 = ha_reg;
                p1 = hc_reg;
                p2 = hv_reg.v2;
            end
        endcase
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {PAD_W'(0), p2, p1, p0};
    assign m_axis_tuser  = cnt_reg;
    assign m_axis_tlast  = (cnt_reg == CHILD_V2);

    `ASSERT_CLK(a_child_order, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser == 2'($past(m_axis_tuser) + 2'd1), "child order broken")
    `ASSERT_NEVER(a_stall_cause, clk, rst_n, !s_axis_tready && !(vld_reg[L-1] && busy_reg), "stall without a full output holder")

endmodule
`default_nettype wire
